FILE: hdl/vconv_pkg.sv
// shared widths, register codes and pipeline tag type for the valid-region convolution core
package vconv_pkg;

  localparam int KSIZE_W    = 3;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COEF_IDX_W = 5;
  localparam int PIX_W      = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = 40;
  localparam int POS_W      = 10;

  localparam logic [KSIZE_W-1:0] KSIZE_RESET = 3'd3;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_COEF  = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_t;

  typedef struct packed {
    logic             is_pixel;
    logic             emit;
    logic             last;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
  } pos_ctrl_t;

endpackage

FILE: hdl/vconv_line_store.sv
// line buffers: one bank per stored image row, read at the column of the incoming pixel
module vconv_line_store #(
  parameter int LROWS = 4,
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int BW    = 2
) (
  input  logic                                  clk,
  input  logic                                  access,
  input  logic [AW-1:0]                         addr,
  input  logic [BW-1:0]                         wr_bank,
  input  logic [vconv_pkg::PIX_W-1:0]           wr_data,
  output logic [LROWS-1:0][vconv_pkg::PIX_W-1:0] rd_data
);

  for (genvar b = 0; b < LROWS; b++) begin : g_bank
    logic [vconv_pkg::PIX_W-1:0] mem [DEPTH];

    // read returns the old word when the same column is written
    always_ff @(posedge clk) begin
      if (access) begin
        rd_data[b] <= mem[addr];
        if (wr_bank == BW'(b)) begin
          mem[addr] <= wr_data;
        end
      end
    end
  end

endmodule

FILE: hdl/vconv_window_mac.sv
// kernel coefficients, sliding window and the parallel product stage
module vconv_window_mac #(
  parameter int KMAX  = 5,
  parameter int LROWS = 4,
  parameter int BW    = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic [vconv_pkg::KSIZE_W-1:0]          k_eff,
  input  vconv_pkg::pos_ctrl_t                   a_ctrl,
  input  logic signed [vconv_pkg::PIX_W-1:0]     a_value,
  input  logic [vconv_pkg::COEF_IDX_W-1:0]       a_coef_idx,
  input  logic [LROWS-1:0]                       line_en,
  input  logic [LROWS-1:0][BW-1:0]               src_bank,
  input  logic [LROWS-1:0][vconv_pkg::PIX_W-1:0] rd_data,
  output logic signed [vconv_pkg::PROD_W-1:0]    prod [KMAX*KMAX],
  output vconv_pkg::pos_ctrl_t                   b_ctrl
);

  localparam int NTAP = KMAX * KMAX;

  logic signed [vconv_pkg::PIX_W-1:0] coefs    [NTAP];
  logic signed [vconv_pkg::PIX_W-1:0] window   [KMAX][KMAX];
  logic signed [vconv_pkg::PIX_W-1:0] win_next [KMAX][KMAX];

  for (genvar t = 0; t < KMAX; t++) begin : g_row
    for (genvar c = 0; c < KMAX; c++) begin : g_col
      logic signed [vconv_pkg::PIX_W-1:0]  cand [KMAX];
      logic signed [vconv_pkg::PIX_W-1:0]  coef_sel;
      logic signed [vconv_pkg::PROD_W-1:0] prod_next;

      // window shifts one column left, new column enters on the right
      if (c < KMAX - 1) begin : g_shift
        assign win_next[t][c] = window[t][c+1];
      end else if (t < LROWS) begin : g_line
        logic signed [vconv_pkg::PIX_W-1:0] line_px;
        assign line_px = line_en[t] ? $signed(rd_data[src_bank[t]]) : '0;
        always_comb begin
          if (k_eff == vconv_pkg::KSIZE_W'(t + 1)) begin
            win_next[t][c] = a_value;
          end else if (k_eff > vconv_pkg::KSIZE_W'(t + 1)) begin
            win_next[t][c] = line_px;
          end else begin
            win_next[t][c] = window[t][c];
          end
        end
      end else begin : g_bottom
        assign win_next[t][c] = (k_eff == vconv_pkg::KSIZE_W'(t + 1)) ? a_value : window[t][c];
      end

      // coefficient for this window cell under each kernel size
      for (genvar kk = 0; kk < KMAX; kk++) begin : g_ksel
        if (t < kk + 1 && c >= KMAX - (kk + 1)) begin : g_use
          assign cand[kk] = (k_eff == vconv_pkg::KSIZE_W'(kk + 1))
                            ? coefs[t*KMAX + c - KMAX + kk + 1] : '0;
        end else begin : g_none
          assign cand[kk] = '0;
        end
      end

      always_comb begin
        coef_sel = '0;
        for (int kk = 0; kk < KMAX; kk++) begin
          coef_sel = coef_sel | cand[kk];
        end
      end

      assign prod_next = coef_sel * win_next[t][c];

      always_ff @(posedge clk) begin
        if (take) begin
          prod[t*KMAX + c] <= prod_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NTAP; i++) begin
        coefs[i] <= '0;
      end
      for (int t = 0; t < KMAX; t++) begin
        for (int c = 0; c < KMAX; c++) begin
          window[t][c] <= '0;
        end
      end
    end else if (take) begin
      if (a_ctrl.is_pixel) begin
        window <= win_next;
      end else begin
        // indexes past the kernel store are dropped
        for (int i = 0; i < NTAP; i++) begin
          if (int'(a_coef_idx) == i) begin
            coefs[i] <= a_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_ctrl <= a_ctrl;
    end
  end

endmodule

FILE: hdl/vconv_adder.sv
// two-level registered adder tree: row sums, then the full window sum
module vconv_adder #(
  parameter int KMAX = 5
) (
  input  logic                                clk,
  input  logic                                ld_c,
  input  logic                                ld_out,
  input  logic signed [vconv_pkg::PROD_W-1:0] prod [KMAX*KMAX],
  input  vconv_pkg::pos_ctrl_t                b_ctrl,
  output logic signed [vconv_pkg::SUM_W-1:0]  conv_sum,
  output vconv_pkg::pos_ctrl_t                out_ctrl
);

  logic signed [vconv_pkg::SUM_W-1:0] row_sum      [KMAX];
  logic signed [vconv_pkg::SUM_W-1:0] row_sum_next [KMAX];
  logic signed [vconv_pkg::SUM_W-1:0] total_next;
  vconv_pkg::pos_ctrl_t               c_ctrl;

  always_comb begin
    for (int t = 0; t < KMAX; t++) begin
      row_sum_next[t] = '0;
      for (int c = 0; c < KMAX; c++) begin
        row_sum_next[t] = row_sum_next[t] + vconv_pkg::SUM_W'(prod[t*KMAX + c]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int t = 0; t < KMAX; t++) begin
      total_next = total_next + row_sum[t];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_c) begin
      row_sum <= row_sum_next;
      c_ctrl  <= b_ctrl;
    end
    if (ld_out) begin
      conv_sum <= total_next;
      out_ctrl <= c_ctrl;
    end
  end

endmodule

FILE: hdl/valid_2d_convolution_core.sv
// top level of the streaming valid-region 2d convolution core
//
// items on the input channel (in_valid/in_ready) either load one kernel
// coefficient (mode 0, coef_index = row*KMAX+col) or carry one image pixel
// (mode 1) in raster order. each pixel whose k-by-k window lies inside the
// image gives one result item on the output channel (out_valid/out_ready):
// the exact 40-bit window sum, its row and column in the valid region and a
// flag on the final result of the image. other items give no result.
// registers are written through cfg_valid/cfg_index/cfg_data, always ready;
// a write restarts the image at row 0, column 0. write them only when idle.
// throughput: one item per cycle unless the receiver stalls. a pixel's result
// passes the line buffer read, window and products, row sums and final sum in
// turn, set by the four-stage pipeline and the registered line buffer read.
// when the receiver stalls the four stages fill and in_ready drops once all
// are occupied; nothing is lost. reset restores the register defaults,
// clears coefficients, window and position; the line buffers are not
// cleared and need no sweep, so the block is ready right after reset.
module valid_2d_convolution_core #(
  parameter int KMAX       = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vconv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vconv_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic [vconv_pkg::COEF_IDX_W-1:0]     coef_index,
  input  logic signed [vconv_pkg::PIX_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vconv_pkg::SUM_W-1:0]   conv_sum,
  output logic [vconv_pkg::POS_W-1:0]          out_row,
  output logic [vconv_pkg::POS_W-1:0]          out_col,
  output logic                                 last
);

  localparam int LROWS = (KMAX > 1) ? KMAX - 1 : 1;
  localparam int BW    = (LROWS > 1) ? $clog2(LROWS) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = (CW + 1 > vconv_pkg::DIM_W) ? CW + 1 : vconv_pkg::DIM_W;
  localparam int HW    = (RW + 1 > vconv_pkg::DIM_W) ? RW + 1 : vconv_pkg::DIM_W;

  logic [vconv_pkg::KSIZE_W-1:0] kernel_size;
  logic [vconv_pkg::DIM_W-1:0]   image_width;
  logic [vconv_pkg::DIM_W-1:0]   image_height;

  logic [vconv_pkg::KSIZE_W-1:0] k_eff;
  logic [WW-1:0]                 w_raw, w_eff, w_last;
  logic [HW-1:0]                 h_raw, h_eff, h_last;

  logic [RW-1:0] pixel_row, pixel_row_next;
  logic [CW-1:0] pixel_col, pixel_col_next;
  logic [BW-1:0] pixel_bank, pixel_bank_next;

  logic          cfg_hit;
  logic          in_fire, pix_fire;
  logic          col_at_end, row_at_end;
  logic [RW-1:0] km1_r;
  logic [CW-1:0] km1_c;

  vconv_pkg::pos_ctrl_t    in_ctrl, a_ctrl, b_ctrl, out_ctrl;
  logic [LROWS-1:0]        line_en, a_line_en;
  logic [LROWS-1:0][BW-1:0] src_bank, a_src_bank;
  logic [LROWS-1:0][vconv_pkg::PIX_W-1:0] rd_data;
  logic signed [vconv_pkg::PIX_W-1:0]     a_value;
  logic [vconv_pkg::COEF_IDX_W-1:0]       a_coef_idx;
  logic signed [vconv_pkg::PROD_W-1:0]    prod [KMAX*KMAX];

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready, out_free;

  // register values outside their range act as the nearest legal value
  assign w_raw = WW'(image_width);
  assign h_raw = HW'(image_height);

  always_comb begin
    if (kernel_size == '0) begin
      k_eff = vconv_pkg::KSIZE_W'(1);
    end else if (kernel_size > vconv_pkg::KSIZE_W'(KMAX)) begin
      k_eff = vconv_pkg::KSIZE_W'(KMAX);
    end else begin
      k_eff = kernel_size;
    end
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = HW'(1);
    end else if (h_raw > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  assign w_last = w_eff - WW'(1);
  assign h_last = h_eff - HW'(1);

  // config port
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (vconv_pkg::cfg_reg_t'(cfg_index))
      vconv_pkg::REG_KERNEL_SIZE,
      vconv_pkg::REG_IMAGE_WIDTH,
      vconv_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_valid;
      default:                     cfg_hit = 1'b0;
    endcase
  end

  // pipeline handshake
  assign out_free = !out_valid || out_ready;
  assign c_ready  = !c_valid || out_free;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign in_fire  = in_valid && in_ready;
  assign pix_fire = in_fire && (mode == vconv_pkg::MODE_PIXEL);

  // raster position
  assign col_at_end = (WW'(pixel_col) == w_last);
  assign row_at_end = (HW'(pixel_row) == h_last);
  assign km1_r      = RW'(k_eff) - RW'(1);
  assign km1_c      = CW'(k_eff) - CW'(1);

  always_comb begin
    pixel_col_next  = pixel_col + CW'(1);
    pixel_row_next  = pixel_row;
    pixel_bank_next = pixel_bank;
    if (col_at_end) begin
      pixel_col_next = '0;
      if (row_at_end) begin
        pixel_row_next  = '0;
        pixel_bank_next = '0;
      end else begin
        pixel_row_next  = pixel_row + RW'(1);
        pixel_bank_next = (pixel_bank == BW'(LROWS - 1)) ? '0 : pixel_bank + BW'(1);
      end
    end
  end

  // which bank feeds each upper window row, and whether that row exists yet
  always_comb begin
    int s;
    for (int t = 0; t < LROWS; t++) begin
      s = int'(pixel_bank) + t + LROWS - (int'(k_eff) - 1);
      if (s >= LROWS) s = s - LROWS;
      if (s >= LROWS) s = s - LROWS;
      src_bank[t] = BW'(s);
      line_en[t]  = (t < int'(k_eff) - 1) && (int'(pixel_row) + t >= int'(k_eff) - 1);
    end
  end

  always_comb begin
    in_ctrl.is_pixel = (mode == vconv_pkg::MODE_PIXEL);
    in_ctrl.emit     = (pixel_row >= km1_r) && (pixel_col >= km1_c);
    in_ctrl.last     = row_at_end && col_at_end;
    in_ctrl.out_row  = vconv_pkg::POS_W'(pixel_row - km1_r);
    in_ctrl.out_col  = vconv_pkg::POS_W'(pixel_col - km1_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= vconv_pkg::KSIZE_RESET;
      image_width  <= vconv_pkg::DIM_RESET;
      image_height <= vconv_pkg::DIM_RESET;
      pixel_row    <= '0;
      pixel_col    <= '0;
      pixel_bank   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (vconv_pkg::cfg_reg_t'(cfg_index))
          vconv_pkg::REG_KERNEL_SIZE:  kernel_size  <= cfg_data[vconv_pkg::KSIZE_W-1:0];
          vconv_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          vconv_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        pixel_row  <= '0;
        pixel_col  <= '0;
        pixel_bank <= '0;
      end else if (pix_fire) begin
        pixel_row  <= pixel_row_next;
        pixel_col  <= pixel_col_next;
        pixel_bank <= pixel_bank_next;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready)  a_valid   <= in_valid;
      if (b_ready)  b_valid   <= a_valid && a_ctrl.is_pixel && a_ctrl.emit;
      if (c_ready)  c_valid   <= b_valid;
      if (out_free) out_valid <= c_valid;
    end
  end

  // stage a payload, alongside the line buffer read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_ctrl     <= in_ctrl;
      a_value    <= value;
      a_coef_idx <= coef_index;
      a_line_en  <= line_en;
      a_src_bank <= src_bank;
    end
  end

  vconv_line_store #(
    .LROWS (LROWS),
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .BW    (BW)
  ) u_line_store (
    .clk     (clk),
    .access  (pix_fire),
    .addr    (pixel_col),
    .wr_bank (pixel_bank),
    .wr_data (value),
    .rd_data (rd_data)
  );

  vconv_window_mac #(
    .KMAX  (KMAX),
    .LROWS (LROWS),
    .BW    (BW)
  ) u_window_mac (
    .clk        (clk),
    .rst        (rst),
    .take       (a_valid && b_ready),
    .k_eff      (k_eff),
    .a_ctrl     (a_ctrl),
    .a_value    (a_value),
    .a_coef_idx (a_coef_idx),
    .line_en    (a_line_en),
    .src_bank   (a_src_bank),
    .rd_data    (rd_data),
    .prod       (prod),
    .b_ctrl     (b_ctrl)
  );

  vconv_adder #(
    .KMAX (KMAX)
  ) u_adder (
    .clk      (clk),
    .ld_c     (b_valid && c_ready),
    .ld_out   (c_valid && out_free),
    .prod     (prod),
    .b_ctrl   (b_ctrl),
    .conv_sum (conv_sum),
    .out_ctrl (out_ctrl)
  );

  assign out_row = out_ctrl.out_row;
  assign out_col = out_ctrl.out_col;
  assign last    = out_ctrl.last;

`ifndef ASSERT_OFF
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WW'(pixel_col) <= w_last)
    else $error("column position beyond image width");

  a_row_in_image: assert property (@(posedge clk) disable iff (rst)
    HW'(pixel_row) <= h_last)
    else $error("row position beyond image height");

  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    pixel_bank <= BW'(LROWS - 1))
    else $error("line bank index out of range");

  a_no_result_item: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_ready && !(a_ctrl.is_pixel && a_ctrl.emit)) |=> !b_valid)
    else $error("item without a result entered the product stage");

  a_stage_a_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_ready) |=> (a_valid && $stable(a_ctrl) && $stable(a_value)))
    else $error("stalled item in stage a changed");
`endif

endmodule
